@@ rtl/core/fnm_pkg.sv @@
// Shared types and constants for the fractal noise mixer.
// Holds the controller state enum, the command and status structs and the CSR indexes.
// No dependencies.
`default_nettype none
package fnm_pkg;

   localparam int RING_DEPTH_DEF   = 1024;
   localparam int SAMPLE_WIDTH_DEF = 24;

   localparam int NOISE_WIDTH  = 17;
   localparam int SCALE_WIDTH  = 18;
   localparam int LEVEL_WIDTH  = 17;
   localparam int GAIN_WIDTH   = 20;
   localparam int LFSR_WIDTH   = 32;
   localparam int CSR_IDX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [LFSR_WIDTH-1:0]  LFSR_MASK   = 32'h8020_0003;
   localparam logic [LFSR_WIDTH-1:0]  LFSR_RESET  = 32'd1;
   localparam logic [SCALE_WIDTH-1:0] INIT_SCALE_RESET = 18'd19661;
   localparam logic [LEVEL_WIDTH-1:0] LEVEL_SCALE_RESET = 17'd65536;
   localparam logic [GAIN_WIDTH-1:0]  GAIN_RESET  = 20'd65536;
   localparam logic [SCALE_WIDTH-1:0] SCALE_MAX   = 18'h3_FFFF;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_INITIAL_SCALE = 3'd0,
      CSR_LEVEL_SCALE   = 3'd1,
      CSR_SIGNAL_GAIN   = 3'd2,
      CSR_NOISE_GAIN    = 3'd3,
      CSR_RANDOM_SEED   = 3'd4
   } csr_index_type;

   typedef enum logic [9:0] {
      ST_IDLE       = 10'b00_0000_0001,
      ST_REGEN_INIT = 10'b00_0000_0010,
      ST_MID_READ   = 10'b00_0000_0100,
      ST_MID_MUL    = 10'b00_0000_1000,
      ST_MID_WRITE  = 10'b00_0001_0000,
      ST_LEVEL_END  = 10'b00_0010_0000,
      ST_NOISE_READ = 10'b00_0100_0000,
      ST_MIX_MUL    = 10'b00_1000_0000,
      ST_MIX_OUT    = 10'b01_0000_0000,
      ST_SPARE      = 10'b10_0000_0000
   } state_type;

   typedef struct packed {
      logic accept;
      logic regen_init;
      logic mid_read;
      logic mid_mul;
      logic mid_write;
      logic level_end;
      logic noise_read;
      logic mix_mul;
      logic mix_out;
   } cmd_type;

   typedef struct packed {
      logic pos_zero;
      logic mid_last;
      logic level_last;
      logic rsp_free;
   } status_type;

endpackage
`default_nettype wire

@@ rtl/core/fnm_ctrl.sv @@
// Controller state machine for the fractal noise mixer.
// Sequences ring regeneration and the output mix; depends on fnm_pkg.
`default_nettype none
module fnm_ctrl
   import fnm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = status.pos_zero ? ST_REGEN_INIT : ST_NOISE_READ;
            end
         end
         ST_REGEN_INIT: begin
            cmd.regen_init = 1'b1;
            state_in       = ST_MID_READ;
         end
         ST_MID_READ: begin
            cmd.mid_read = 1'b1;
            state_in     = ST_MID_MUL;
         end
         ST_MID_MUL: begin
            cmd.mid_mul = 1'b1;
            state_in    = ST_MID_WRITE;
         end
         ST_MID_WRITE: begin
            cmd.mid_write = 1'b1;
            state_in      = status.mid_last ? ST_LEVEL_END : ST_MID_READ;
         end
         ST_LEVEL_END: begin
            cmd.level_end = 1'b1;
            state_in      = status.level_last ? ST_NOISE_READ : ST_MID_READ;
         end
         ST_NOISE_READ: begin
            cmd.noise_read = 1'b1;
            state_in       = ST_MIX_MUL;
         end
         ST_MIX_MUL: begin
            cmd.mix_mul = 1'b1;
            state_in    = ST_MIX_OUT;
         end
         ST_MIX_OUT: begin
            // hold until the output word is free
            if (status.rsp_free) begin
               cmd.mix_out = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> !req_tready)
      else $error("controller stayed idle after accepting a word");

   a_out_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.mix_out |-> status.rsp_free)
      else $error("result issued while output word busy");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one command at once");

endmodule
`default_nettype wire

@@ rtl/core/fnm_dpath.sv @@
// Datapath for the fractal noise mixer: CSRs, LFSR, noise ring memory,
// midpoint arithmetic and output mix. Depends on fnm_pkg; driven by fnm_ctrl.
`default_nettype none
module fnm_dpath
   import fnm_pkg::*;
#(
   parameter int RING_DEPTH   = RING_DEPTH_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cmd_type                   cmd,
   output status_type                     status,
   input  wire logic [SAMPLE_WIDTH-1:0]   in_sample,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [SAMPLE_WIDTH-1:0]        out_sample,
   input  wire logic                      csr_valid,
   input  wire logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_data
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam int LW = AW + 1;
   localparam int CW = LW + 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);
   localparam int SH = SAMPLE_WIDTH - 16;
   localparam int P1W = SAMPLE_WIDTH + GAIN_WIDTH + 1;
   localparam int P2W = NOISE_WIDTH + GAIN_WIDTH + 1;
   localparam int TW  = SAMPLE_WIDTH + GAIN_WIDTH + 3;
   localparam logic signed [TW-1:0] OUT_MAX = TW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
   localparam logic signed [TW-1:0] OUT_MIN = -TW'(64'sd1 <<< (SAMPLE_WIDTH - 1));

   // configuration
   logic [SCALE_WIDTH-1:0] init_scale_ff;
   logic [LEVEL_WIDTH-1:0] level_scale_ff;
   logic [GAIN_WIDTH-1:0]  signal_gain_ff, noise_gain_ff;
   logic [LFSR_WIDTH-1:0]  lfsr_ff, lfsr_in;

   // regeneration state
   logic [SCALE_WIDTH-1:0] scale_ff;
   logic [LW-1:0]          len_ff;
   logic [AW-1:0]          lo_ff;
   logic [AW-1:0]          pos_ff;
   logic [SAMPLE_WIDTH-1:0] sample_ff;

   // ring memory
   logic [NOISE_WIDTH-1:0] ring_mem [RING_DEPTH];
   logic [AW-1:0]          addr_a, addr_b, wr_addr;
   logic                   wr_en;
   logic [NOISE_WIDTH-1:0] wr_data;
   logic [NOISE_WIDTH-1:0] rd_a_ff, rd_b_ff;

   logic signed [NOISE_WIDTH-1:0]   half_ff;
   logic signed [34:0]              disp_prod_ff;
   logic signed [P1W-1:0]           p1_ff;
   logic signed [P2W-1:0]           p2_ff;
   logic                            rsp_valid_ff;
   logic [SAMPLE_WIDTH-1:0]         out_ff;

   logic [CW-1:0] lo_ext, len_ext, hi_sum;
   logic [AW-1:0] hi_addr, mid_addr;
   logic signed [NOISE_WIDTH:0]     pair_sum;
   logic signed [15:0]              uni;
   logic signed [19:0]              disp;
   logic signed [20:0]              mid_v;
   logic [34:0]                     scale_prod;
   logic [18:0]                     scale_shr;
   logic signed [TW-1:0]            total, mix_v;

   assign lo_ext   = CW'(lo_ff);
   assign len_ext  = CW'(len_ff);
   assign hi_sum   = lo_ext + len_ext;
   assign hi_addr  = (hi_sum == DEPTH_C) ? '0 : hi_sum[AW-1:0];
   assign mid_addr = lo_ff + AW'(len_ff >> 1);

   assign status.pos_zero   = (pos_ff == '0);
   assign status.mid_last   = (hi_sum + len_ext > DEPTH_C);
   assign status.level_last = (len_ff < LW'(4));
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   // LFSR and CSRs
   always_comb begin
      lfsr_in = lfsr_ff;
      if (cmd.mid_read) begin
         lfsr_in = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? LFSR_MASK : '0);
      end
      if (csr_valid && csr_index == CSR_RANDOM_SEED) begin
         lfsr_in = (csr_data == '0) ? LFSR_RESET : csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_scale_ff  <= INIT_SCALE_RESET;
         level_scale_ff <= LEVEL_SCALE_RESET;
         signal_gain_ff <= GAIN_RESET;
         noise_gain_ff  <= GAIN_RESET;
         lfsr_ff        <= LFSR_RESET;
      end else begin
         lfsr_ff <= lfsr_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_INITIAL_SCALE: init_scale_ff  <= csr_data[SCALE_WIDTH-1:0];
               CSR_LEVEL_SCALE:   level_scale_ff <= csr_data[LEVEL_WIDTH-1:0];
               CSR_SIGNAL_GAIN:   signal_gain_ff <= csr_data[GAIN_WIDTH-1:0];
               CSR_NOISE_GAIN:    noise_gain_ff  <= csr_data[GAIN_WIDTH-1:0];
               default: ;
            endcase
         end
      end
   end

   // memory ports
   assign addr_a  = cmd.noise_read ? pos_ff : lo_ff;
   assign addr_b  = hi_addr;
   assign wr_en   = cmd.regen_init || cmd.mid_write;
   assign wr_addr = cmd.regen_init ? '0 : mid_addr;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= ring_mem[addr_a];
      rd_b_ff <= ring_mem[addr_b];
   end

   // midpoint arithmetic
   assign pair_sum = {rd_a_ff[NOISE_WIDTH-1], rd_a_ff} + {rd_b_ff[NOISE_WIDTH-1], rd_b_ff};
   assign uni      = $signed({~lfsr_ff[31], lfsr_ff[30:16]});
   assign disp     = 20'(disp_prod_ff >>> 16);
   assign mid_v    = 21'(half_ff) + 21'(disp);

   always_comb begin
      if (cmd.regen_init) begin
         wr_data = '0;
      end else if (mid_v > 21'sd32768) begin
         wr_data = 17'sd32768;
      end else if (mid_v < -21'sd32768) begin
         wr_data = -17'sd32768;
      end else begin
         wr_data = mid_v[NOISE_WIDTH-1:0];
      end
   end

   assign scale_prod = 35'(scale_ff) * 35'(level_scale_ff);
   assign scale_shr  = scale_prod[34:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         scale_ff <= '0;
         len_ff   <= '0;
         lo_ff    <= '0;
      end else begin
         if (cmd.regen_init) begin
            scale_ff <= init_scale_ff;
            len_ff   <= LW'(RING_DEPTH);
            lo_ff    <= '0;
         end
         if (cmd.mid_write) begin
            lo_ff <= hi_sum[AW-1:0];
         end
         if (cmd.level_end) begin
            scale_ff <= (scale_shr > 19'(SCALE_MAX)) ? SCALE_MAX : scale_shr[SCALE_WIDTH-1:0];
            len_ff   <= len_ff >> 1;
            lo_ff    <= '0;
         end
         if (cmd.noise_read) begin
            pos_ff <= (CW'(pos_ff) + CW'(1) == DEPTH_C) ? '0 : pos_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= in_sample;
      end
      if (cmd.mid_mul) begin
         half_ff      <= pair_sum[NOISE_WIDTH:1];
         disp_prod_ff <= $signed({1'b0, scale_ff}) * uni;
      end
      if (cmd.mix_mul) begin
         p1_ff <= $signed({1'b0, signal_gain_ff}) * $signed(sample_ff);
         p2_ff <= $signed({1'b0, noise_gain_ff}) * $signed(rd_a_ff);
      end
   end

   // output mix and saturation
   assign total = TW'(p1_ff) + (TW'(p2_ff) <<< SH);
   assign mix_v = total >>> 16;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.mix_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mix_out) begin
         if (mix_v > OUT_MAX) begin
            out_ff <= OUT_MAX[SAMPLE_WIDTH-1:0];
         end else if (mix_v < OUT_MIN) begin
            out_ff <= OUT_MIN[SAMPLE_WIDTH-1:0];
         end else begin
            out_ff <= mix_v[SAMPLE_WIDTH-1:0];
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign out_sample = out_ff;

   a_mid_never_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.mid_write |-> (mid_addr != '0))
      else $error("midpoint write hit entry zero");

   a_span_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.mid_read |-> (hi_sum <= DEPTH_C && len_ff >= LW'(2)))
      else $error("midpoint span runs past the ring");

   a_out_loads_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.mix_out |=> rsp_valid_ff)
      else $error("output word not marked valid");

endmodule
`default_nettype wire

@@ rtl/core/fractal_noise_mixer_top.sv @@
// Top level of the fractal noise mixer: stream ports, controller and datapath.
// Depends on fnm_pkg, fnm_ctrl and fnm_dpath.
//
//   channel  direction  word
//   req_     in         tdata[SAMPLE_WIDTH-1:0] = in_sample
//   rsp_     out        tdata[SAMPLE_WIDTH-1:0] = out_sample
//   csr_     in         index 0..4, data 32 bits
//
// When the read position is zero the ring is rebuilt first: a start step, then per
// level each midpoint is read, multiplied and written on the ring memory, and a
// level-end step closes the level.
// Reset is synchronous; the ring memory holds no reset contents.
// A stalled result holds in the output register; the next word is accepted meanwhile.
`default_nettype none
module fractal_noise_mixer_top
   import fnm_pkg::*;
#(
   parameter int RING_DEPTH   = RING_DEPTH_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   localparam int DW = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [DW-1:0]             req_tdata,  // in_sample
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [DW-1:0]                  rsp_tdata,  // out_sample
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_data
);

   cmd_type                 cmd;
   status_type              status;
   logic [SAMPLE_WIDTH-1:0] out_sample;

   assign csr_ready = 1'b1;
   assign rsp_tdata = DW'(out_sample);

   fnm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fnm_dpath #(
      .RING_DEPTH   (RING_DEPTH),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .in_sample  (req_tdata[SAMPLE_WIDTH-1:0]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .out_sample (out_sample),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

endmodule
`default_nettype wire

@@ test/tb.sv @@
// Self-checking bench for fractal_noise_mixer_top: random and directed samples,
// CSR phases, a bit-exact ring predictor and an in-order output checker.
// Depends on fnm_pkg and the RTL under rtl/core.
module tb
   import fnm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = RING_DEPTH_DEF;
   localparam int SW = SAMPLE_WIDTH_DEF;
   localparam int STALL_LIMIT = 20000;
   localparam int HOLD_LEN = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [23:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = CSR_INITIAL_SCALE;
   logic [31:0] csr_data = '0;

   always #5 clock = ~clock;

   fractal_noise_mixer_top uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata),  // in_sample
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),  // out_sample
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data));

   // predictor state
   int noise_mem [DEPTH];
   int unsigned rd_pos;
   logic [31:0] lfsr;
   longint unsigned disp_scale;
   longint unsigned init_scale_r, level_scale_r, sig_gain_r, noise_gain_r;

   logic [23:0] sample_queue [$];
   logic [23:0] mix_expected [$];
   int errors = 0;
   int n_checked = 0;
   int send_idle_pct = 0, recv_stall_pct = 0;
   int hold_cycles = 0;
   int hold_request = 0;
   int hold_served = 0;
   int quiet_cycles = 0;
   bit csr_busy = 0;

   function automatic longint floor_q16(longint p);
      return p >>> 16;
   endfunction

   function automatic longint next_uniform();
      logic lsb;
      lsb = lfsr[0];
      lfsr = lfsr >> 1;
      if (lsb) lfsr = lfsr ^ LFSR_MASK;
      return longint'(lfsr[31:16]) - 32768;
   endfunction

   function automatic void rebuild_ring();
      int unsigned lvl, lo, hi, mid;
      longint s, half, v, ns;
      disp_scale = init_scale_r;
      noise_mem[0] = 0;
      lvl = DEPTH;
      while (lvl > 1) begin
         for (int unsigned c = 0; c < DEPTH / lvl; c++) begin
            lo = c * lvl;
            hi = ((c + 1) * lvl) % DEPTH;
            mid = lo + lvl / 2;
            s = longint'(noise_mem[lo]) + noise_mem[hi];
            half = s >>> 1;
            v = half + floor_q16(longint'(disp_scale) * next_uniform());
            if (v > 32768) v = 32768;
            if (v < -32768) v = -32768;
            noise_mem[mid] = int'(v);
         end
         lvl = lvl / 2;
         ns = longint'((disp_scale * level_scale_r) >> 16);
         if (ns > 262143) ns = 262143;
         disp_scale = longint'(ns);
      end
   endfunction

   function automatic logic [23:0] mix_sample(logic [23:0] raw);
      longint x, nv, y;
      if (rd_pos == 0) rebuild_ring();
      x = longint'(signed'(raw));
      nv = noise_mem[rd_pos];
      noise_mem[rd_pos] = 0;
      rd_pos = (rd_pos + 1) % DEPTH;
      y = floor_q16(longint'(sig_gain_r) * x
                    + longint'(noise_gain_r) * nv * (longint'(1) << (SW - 16)));
      if (y > 8388607) y = 8388607;
      if (y < -8388608) y = -8388608;
      return y[23:0];
   endfunction

   task automatic model_csr(csr_index_type idx, logic [31:0] val);
      case (idx)
         CSR_INITIAL_SCALE: init_scale_r = val & 32'h3FFFF;
         CSR_LEVEL_SCALE: level_scale_r = val & 32'h1FFFF;
         CSR_SIGNAL_GAIN: sig_gain_r = val & 32'hFFFFF;
         CSR_NOISE_GAIN: noise_gain_r = val & 32'hFFFFF;
         CSR_RANDOM_SEED: lfsr = (val == 0) ? 32'd1 : val;
         default: ;
      endcase
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata <= sample_queue.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // accept side: predict on every accepted word
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         mix_expected.push_back(mix_sample(req_tdata));
   end

   // receiver with stall and long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_served != hold_request) begin
         hold_served <= hold_request;
         hold_cycles <= HOLD_LEN;
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (mix_expected.size() == 0) begin
            $error("unexpected word: out_sample actual %0d", signed'(rsp_tdata));
            errors++;
         end else begin
            logic [23:0] want;
            want = mix_expected.pop_front();
            if (want !== rsp_tdata) begin
               $error("out_sample mismatch: expected %0d actual %0d",
                      signed'(want), signed'(rsp_tdata));
               errors++;
            end
            n_checked++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_busy)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog expired");
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic write_csr(csr_index_type idx, logic [31:0] val);
      csr_busy = 1;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      model_csr(idx, val);
      // drop csr_valid between writes
      @(posedge clock);
      csr_busy = 0;
   endtask

   task automatic drain();
      while (sample_queue.size() > 0 || req_tvalid || mix_expected.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [23:0] rand_sample();
      case ($urandom_range(5))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'(signed'($urandom_range(64)) - 32);
         default: return 24'($urandom);
      endcase
   endfunction

   initial begin
      init_scale_r = 19661;
      level_scale_r = 65536;
      sig_gain_r = 65536;
      noise_gain_r = 65536;
      lfsr = 32'd1;
      rd_pos = 0;
      foreach (noise_mem[i]) noise_mem[i] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes and every bit of the sample
      foreach (sample_queue[i]) ;
      sample_queue.push_back(24'h7FFFFF);
      sample_queue.push_back(24'h800000);
      sample_queue.push_back(24'h000000);
      sample_queue.push_back(24'hFFFFFF);
      sample_queue.push_back(24'h000001);
      sample_queue.push_back(24'h555555);
      sample_queue.push_back(24'hAAAAAA);
      drain();

      // extreme gains and scales; zero seed, oversized gain value via masking
      write_csr(CSR_SIGNAL_GAIN, 32'hFFFFFFFF);
      write_csr(CSR_NOISE_GAIN, 32'd655360);
      write_csr(CSR_INITIAL_SCALE, 32'd150733);
      write_csr(CSR_LEVEL_SCALE, 32'h1FFFF);
      write_csr(CSR_RANDOM_SEED, 32'd0);
      for (int i = 0; i < 14; i++) sample_queue.push_back(i[0] ? 24'h7FFFFF : 24'h800000);
      drain();

      // random phases across idling patterns and settings
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 45; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 45; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
         endcase
         write_csr(CSR_INITIAL_SCALE, $urandom_range(150733));
         write_csr(CSR_LEVEL_SCALE, (ph == 4) ? 32'd32768 : $urandom_range(65536, 32768));
         write_csr(CSR_SIGNAL_GAIN, (ph == 5) ? 32'd0 : $urandom_range(655360));
         write_csr(CSR_NOISE_GAIN, (ph == 6) ? 32'd0 : $urandom_range(655360));
         write_csr(CSR_RANDOM_SEED, $urandom | 32'd1);
         if (ph == 2) hold_request++;
         for (int i = 0; i < 129; i++) sample_queue.push_back(rand_sample());
         drain();
      end

      $display("checked %0d output words over 10 setting phases incl. ring rebuilds",
               n_checked);
      if (errors == 0 && mix_expected.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end
endmodule
